// File: sv/anem_pkg.sv
package anem_pkg;

  // Ring geometry and field widths.
  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int N_W         = $clog2(MAX_SAMPLES + 1);
  localparam int CNT_W       = 8;
  localparam int TICK_W      = 16;
  localparam int SUM_W       = $clog2(MAX_SAMPLES * 255 + 1);
  localparam int DIV_CNT_W   = $clog2(SUM_W);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // Trimming rule: at TRIM_THRESHOLD entries or more, drop minimum and maximum.
  localparam logic [N_W-1:0] TRIM_THRESHOLD = N_W'(5);
  localparam logic [N_W-1:0] TRIM_DROP      = N_W'(2);

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_WINDOW_TICKS = 1'b1;

  localparam logic [N_W-1:0]    SAMPLE_COUNT_RST = N_W'(8);
  localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = TICK_W'(1000);

  // Ring memory access request.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } anem_ring_req_t;

  // Divider start request.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [N_W-1:0]   den;
  } anem_div_req_t;

endpackage

// File: sv/anemometer_edge_count_trimmed_mean.sv
// Sequence: after the edge that accepts the closing sample, the block walks the ring, sets up
// the divider, divides, and then loads the output register that presents the result.
// Throughput: samples that do not close a window are taken one per cycle; after a closing
// sample the input is held off until the result is loaded into the output register, which
// also waits for any earlier result to be taken.
// Reset (synchronous, active high) clears control state, registers and ring valid bits.
module anemometer_edge_count_trimmed_mean
  import anem_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [0] pin_level, [7:1] zero
  // Output stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [7:0] mean_rotations, [15:8] last_count
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  state_t            state;
  logic [N_W-1:0]    sample_count;
  logic [TICK_W-1:0] window_ticks;
  logic              window_active;
  logic [TICK_W-1:0] tick_counter;
  logic [CNT_W-1:0]  edge_count;
  logic              previous_level;
  logic [IDX_W-1:0]  write_index;
  logic [N_W-1:0]    walk_addr;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  mean;

  logic              in_beat;
  logic              cfg_wr;
  logic              level;
  logic [N_W-1:0]    n_eff;
  logic [TICK_W-1:0] limit;
  logic [CNT_W-1:0]  edge_next;
  logic [TICK_W-1:0] tick_next;
  logic              close;
  logic [IDX_W-1:0]  wi_eff;
  logic [N_W-1:0]    wi_inc;
  logic [IDX_W-1:0]  write_index_next;
  logic [CNT_W-1:0]  ring_rd_data;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  anem_ring_req_t    ring_req;
  anem_div_req_t     div_req;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign level    = s_tdata[0];

  // Register readback.
  always_comb begin
    case (paddr[2])
      REG_SAMPLE_COUNT: prdata = DATA_W'(sample_count);
      REG_WINDOW_TICKS: prdata = DATA_W'(window_ticks);
      default:          prdata = '0;
    endcase
  end

  // Effective ring length and window length.
  always_comb begin
    if (sample_count == '0) begin
      n_eff = N_W'(1);
    end else if (sample_count > N_W'(MAX_SAMPLES)) begin
      n_eff = N_W'(MAX_SAMPLES);
    end else begin
      n_eff = sample_count;
    end
    limit = (window_ticks == '0) ? TICK_W'(1) : window_ticks;
  end

  // Edge counting for one sample of an open window.
  always_comb begin
    edge_next = edge_count;
    if ((level != previous_level) && (edge_count != CNT_MAX)) begin
      edge_next = edge_count + 1'b1;
    end
    tick_next = (tick_counter != TICK_MAX) ? tick_counter + 1'b1 : tick_counter;
    close     = (tick_next >= limit);
  end

  // Ring write slot and the following one.
  always_comb begin
    wi_eff           = ({1'b0, write_index} >= n_eff) ? '0 : write_index;
    wi_inc           = {1'b0, wi_eff} + 1'b1;
    write_index_next = (wi_inc >= n_eff) ? '0 : wi_inc[IDX_W-1:0];
  end

  // Ring accesses: store on closing, then walk entries 0 to n-1.
  always_comb begin
    ring_req.wr_en   = in_beat && window_active && close;
    ring_req.wr_addr = wi_eff;
    ring_req.wr_data = edge_next;
    ring_req.rd_en   = (state == S_WALK) && (walk_addr < n_eff);
    ring_req.rd_addr = walk_addr[IDX_W-1:0];
  end

  // Divider operands, trimmed when enough entries are present.
  always_comb begin
    div_req.start = (state == S_PREP);
    if (n_eff < TRIM_THRESHOLD) begin
      div_req.num = sum;
      div_req.den = n_eff;
    end else begin
      div_req.num = sum - SUM_W'(lo) - SUM_W'(hi);
      div_req.den = n_eff - TRIM_DROP;
    end
  end

  anem_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (ring_req),
    .rd_data (ring_rd_data)
  );

  anem_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // Sequencer, window state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sample_count   <= SAMPLE_COUNT_RST;
      window_ticks   <= WINDOW_TICKS_RST;
      window_active  <= 1'b0;
      tick_counter   <= '0;
      edge_count     <= '0;
      previous_level <= 1'b0;
      write_index    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr) begin
        case (paddr[2])
          REG_SAMPLE_COUNT: begin
            sample_count <= pwdata[N_W-1:0];
            write_index  <= '0;
          end
          REG_WINDOW_TICKS: window_ticks <= pwdata[TICK_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (!window_active) begin
              if (level) begin
                window_active  <= 1'b1;
                previous_level <= 1'b1;
                edge_count     <= '0;
                tick_counter   <= '0;
              end
            end else begin
              edge_count     <= edge_next;
              previous_level <= level;
              if (close) begin
                window_active <= 1'b0;
                tick_counter  <= '0;
                write_index   <= write_index_next;
                walk_addr     <= '0;
                sum           <= '0;
                lo            <= CNT_MAX;
                hi            <= '0;
                state         <= S_WALK;
              end else begin
                tick_counter <= tick_next;
              end
            end
          end
        end
        S_WALK: begin
          // Read data arrives in the cycle after its address.
          if (walk_addr != '0) begin
            sum <= sum + SUM_W'(ring_rd_data);
            if (ring_rd_data < lo) begin
              lo <= ring_rd_data;
            end
            if (ring_rd_data > hi) begin
              hi <= ring_rd_data;
            end
          end
          if (walk_addr == n_eff) begin
            state <= S_PREP;
          end else begin
            walk_addr <= walk_addr + 1'b1;
          end
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mean  <= div_quo[CNT_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {edge_count, mean};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The ring is written only by an accepted sample that closes the window.
  a_ring_write_on_close: assert property (@(posedge clk) disable iff (rst)
    ring_req.wr_en |-> (in_beat && window_active))
    else $error("ring written outside a closing sample");

  // The walk never runs past the effective count.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_addr <= n_eff))
    else $error("ring walk address out of range");

  // A finished division always leads to the output state.
  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> (state == S_OUT))
    else $error("divider result lost");

  // A new result appears only from the output state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the output state");

  // The divider is never started while a division is pending.
  a_single_div: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> (state == S_DIV))
    else $error("divider start without wait state");
`endif

endmodule

// File: sv/anem_ring.sv
module anem_ring
  import anem_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  anem_ring_req_t   req,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0]       mem [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] valid;
  logic [CNT_W-1:0]       rd_raw;
  logic                   rd_valid;

  // Entry storage and registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_addr];
    end
  end

  // Valid bits stand in for clearing the ring at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr];
      end
    end
  end

  // An entry never written reads as zero.
  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

// File: sv/anem_div.sv
module anem_div
  import anem_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  anem_div_req_t    req,
  output logic             done,
  output logic [SUM_W-1:0] quo
);

  logic [N_W-1:0]       rem;
  logic [N_W-1:0]       den;
  logic [DIV_CNT_W-1:0] step;
  logic                 busy;
  logic [N_W:0]         rem_sh;
  logic                 ge;

  // One restoring step: shift in the next numerator bit and try a subtract.
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= DIV_CNT_W'(SUM_W - 1);
        rem  <= '0;
        den  <= req.den;
        quo  <= req.num;
      end else if (busy) begin
        rem <= ge ? N_W'(rem_sh - {1'b0, den}) : rem_sh[N_W-1:0];
        quo <= {quo[SUM_W-2:0], ge};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

// File: dv/anemometer_edge_count_trimmed_mean_tb.sv
module anemometer_edge_count_trimmed_mean_tb;
  import anem_pkg::*;

  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 100;

  // One output beat: the mean over the ring and the count of the closing window.
  typedef struct packed {
    logic [CNT_W-1:0] mean_rot;
    logic [CNT_W-1:0] last_cnt;
  } rotation_t;

  // Shapes of pin activity inside one counting window.
  typedef enum int {PAT_RANDOM, PAT_TOGGLE, PAT_HIGH, PAT_LOW} pat_t;

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;   // [0] pin_level, [7:1] zero
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;         // [7:0] mean_rotations, [15:8] last_count
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Predictor state, mirrored from the block's behavior.
  logic [6:0]        samples_cfg = SAMPLE_COUNT_RST;
  logic [TICK_W-1:0] ticks_cfg   = WINDOW_TICKS_RST;
  logic              window_open = 1'b0;
  int                ticks_seen  = 0;
  int                edges_seen  = 0;
  logic              last_level  = 1'b0;
  logic [CNT_W-1:0]  stored_counts [MAX_SAMPLES] = '{default: '0};
  int                store_ptr   = 0;

  rotation_t expected_means[$];
  int        mismatches   = 0;
  int        quiet_cycles = 0;
  int        rx_hold      = 0;
  bit        tx_idle_en   = 1'b1;
  bit        rx_idle_en   = 1'b1;

  anemometer_edge_count_trimmed_mean dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_error(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Advance the mirrored state by one accepted pin sample.
  task automatic predict_sample(input logic lvl);
    int        n;
    int        limit_ticks;
    int        sum;
    int        lo;
    int        hi;
    rotation_t res;
    if (!window_open) begin
      if (lvl) begin
        window_open = 1'b1;
        last_level  = 1'b1;
        edges_seen  = 0;
        ticks_seen  = 0;
      end
      return;
    end
    if (lvl != last_level && edges_seen < 255) edges_seen++;
    last_level = lvl;
    if (ticks_seen < 16'hFFFF) ticks_seen++;
    limit_ticks = (ticks_cfg == 0) ? 1 : int'(ticks_cfg);
    if (ticks_seen < limit_ticks) return;

    // The window closes: store its count and average the ring.
    n = (samples_cfg == 0) ? 1 : (samples_cfg > MAX_SAMPLES) ? MAX_SAMPLES : int'(samples_cfg);
    if (store_ptr >= n) store_ptr = 0;
    stored_counts[store_ptr] = edges_seen[CNT_W-1:0];
    store_ptr++;
    if (store_ptr >= n) store_ptr = 0;
    window_open = 1'b0;
    ticks_seen  = 0;

    sum = 0;
    lo  = 255;
    hi  = 0;
    for (int i = 0; i < n; i++) begin
      sum += stored_counts[i];
      if (stored_counts[i] < lo) lo = stored_counts[i];
      if (stored_counts[i] > hi) hi = stored_counts[i];
    end
    if (n < TRIM_THRESHOLD) res.mean_rot = CNT_W'(sum / n);
    else res.mean_rot = CNT_W'((sum - lo - hi) / (n - TRIM_DROP));
    res.last_cnt = edges_seen[CNT_W-1:0];
    expected_means.push_back(res);
  endtask

  // Sample every handshake at the rising edge: predict, update registers, check results.
  always @(posedge clk) begin
    rotation_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_means.size() == 0) begin
          report_error($sformatf("unexpected result beat %h", m_tdata));
        end else begin
          want = expected_means.pop_front();
          if (m_tdata[7:0] !== want.mean_rot)
            report_error($sformatf("mean_rotations got %0d, expected %0d",
                                   m_tdata[7:0], want.mean_rot));
          if (m_tdata[15:8] !== want.last_cnt)
            report_error($sformatf("last_count got %0d, expected %0d",
                                   m_tdata[15:8], want.last_cnt));
        end
        rx_hold = rx_idle_en ? $urandom_range(0, 3) : 0;
      end
      if (s_tvalid && s_tready) predict_sample(s_tdata[0]);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SAMPLE_COUNT) begin
          samples_cfg = pwdata[6:0];
          store_ptr   = 0;
        end else begin
          ticks_cfg = pwdata[TICK_W-1:0];
        end
      end
    end
  end

  // Receiver: hold tready low until the result has waited its drawn number of cycles.
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      if (m_tvalid) rx_hold = rx_hold - 1;
    end
  end

  // Watchdog on cycles in which no beat and no register access completes.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_level(input logic lvl);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, lvl};
    do @(posedge clk); while (!s_tready);
  endtask

  // An opening high sample followed by len samples of the chosen shape.
  task automatic send_window(input int len, input pat_t pat);
    logic lvl;
    send_level(1'b1);
    lvl = 1'b1;
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_TOGGLE: lvl = ~lvl;
        PAT_HIGH:   lvl = 1'b1;
        PAT_LOW:    lvl = 1'b0;
        default:    lvl = 1'($urandom_range(0, 1));
      endcase
      send_level(lvl);
    end
  endtask

  // Stop the input, wait for all results, then let the block go quiet.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic reg_idx, input logic [DATA_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_error($sformatf("register %0d read %h, expected %h", reg_idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int samples, input int ticks);
    write_reg(REG_SAMPLE_COUNT, DATA_W'(samples));
    write_reg(REG_WINDOW_TICKS, DATA_W'(ticks));
    check_reg(REG_SAMPLE_COUNT, DATA_W'(samples_cfg));
    check_reg(REG_WINDOW_TICKS, DATA_W'(ticks_cfg));
  endtask

  // Idle low samples are ignored; a high one opens the window without being counted.
  task automatic test_idle_and_open();
    set_config(3, 2);
    send_level(1'b0);
    send_level(1'b0);
    send_window(2, PAT_TOGGLE);
    send_window(2, PAT_HIGH);
    drain();
  endtask

  // A zero sample count acts as one, and zero window ticks close after one sample.
  task automatic test_zero_settings();
    set_config(0, 0);
    send_window(1, PAT_LOW);
    send_window(1, PAT_HIGH);
    send_level(1'b0);
    drain();
  endtask

  // Count clamped to the ring size, then the smallest count that trims.
  task automatic test_ring_extremes();
    set_config(127, 1);
    send_window(1, PAT_LOW);
    send_window(1, PAT_HIGH);
    drain();
    set_config(5, 1);
    repeat (3) send_window(1, PAT_TOGGLE);
    drain();
  endtask

  // Lowering window_ticks below the ticks already counted closes on the next sample.
  task automatic test_window_shrink();
    set_config(4, 16'hFFFF);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    drain();
    write_reg(REG_WINDOW_TICKS, DATA_W'(2));
    send_level(1'b1);
    drain();
  endtask

  // Mostly whole windows with random content, with some stray samples between them.
  task automatic test_random_traffic();
    int samples;
    int ticks;
    int len;
    int sent;
    for (int phase = 0; phase < 7; phase++) begin
      drain();
      case ($urandom_range(0, 9))
        0:       samples = $urandom_range(0, 127);
        1:       samples = MAX_SAMPLES;
        default: samples = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 7))
        0:       ticks = 0;
        1:       ticks = $urandom_range(13, 40);
        default: ticks = $urandom_range(1, 12);
      endcase
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      set_config(samples, ticks);
      len  = (ticks == 0) ? 1 : ticks;
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3)) send_level(1'($urandom_range(0, 1)));
        end else begin
          send_window(len, pat_t'($urandom_range(0, 3)));
          sent += len + 1;
        end
      end
    end
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // A window with more level changes than the count can hold.
  task automatic test_edge_saturation();
    set_config(2, 300);
    send_window(300, PAT_TOGGLE);
    send_window(300, PAT_RANDOM);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_and_open();
    test_zero_settings();
    test_ring_extremes();
    test_window_shrink();
    test_random_traffic();
    test_edge_saturation();
    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
